>>> design/gba_pkg.sv
// Package for the grouped bitmap allocator: geometry constants, codes and word types.
// It depends on nothing; the interfaces and the top level import it.
package gba_pkg;

    localparam int MAX_GROUPS      = 16;
    localparam int BITS_PER_GROUP  = 8192;
    localparam int WORDS_PER_GROUP = (BITS_PER_GROUP + 63) / 64;
    localparam int GROUP_W         = $clog2(MAX_GROUPS);
    localparam int WORD_W          = $clog2(WORDS_PER_GROUP);
    localparam int ADDR_W          = GROUP_W + WORD_W;
    localparam int DEPTH           = MAX_GROUPS * WORDS_PER_GROUP;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_FULL    = 2'd1,
        ST_RANGE   = 2'd2,
        ST_ALREADY = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        CFG_ITEMS  = 2'd0,
        CFG_GROUPS = 2'd1,
        CFG_BASE   = 2'd2,
        CFG_NONE   = 2'd3
    } t_cfg_idx;

    localparam logic REQ_ALLOC = 1'b0;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_A_RD,
        S_A_CHK,
        S_DIV,
        S_F_RD,
        S_F_CHK,
        S_FIN
    } t_state;

    typedef struct packed {
        logic        req_type;
        logic [17:0] item_id;
    } t_req;

    typedef struct packed {
        logic [1:0]  status;
        logic [17:0] result_id;
        logic [3:0]  group_index;
        logic [13:0] group_free;
        logic [17:0] total_free;
    } t_rsp;

endpackage

>>> design/gba_req_if.sv
// Request channel of the allocator: valid, ready and one request word.
// It depends on gba_pkg.
interface gba_req_if import gba_pkg::*; ();
    logic valid;
    logic ready;
    t_req payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

>>> design/gba_rsp_if.sv
// Response channel of the allocator: valid, ready and one result word.
// It depends on gba_pkg.
interface gba_rsp_if import gba_pkg::*; ();
    logic valid;
    logic ready;
    t_rsp payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

>>> design/grouped_bitmap_allocator.sv
// Grouped first-fit bitmap allocator, top level; uses gba_pkg, gba_req_if and gba_rsp_if.
// After reset the bitmap memory is cleared one word a cycle, all 2048 words, before the first
// word is taken. An allocate reads one 64-bit bitmap word at a time (states S_A_RD, S_A_CHK)
// from group 0 word 0 upward; a free runs a bit-serial id division of 18 quotient bits, then
// the read (S_F_RD), and the check and write-back (S_F_CHK).
module grouped_bitmap_allocator import gba_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [13:0] i_cfg_data,
    gba_req_if.sink     i_req,
    gba_rsp_if.source   o_rsp
);

    logic [13:0] r_ipg_cfg;
    logic [4:0]  r_ng_cfg;
    logic        r_base;

    logic [63:0] mem [DEPTH];
    logic [63:0] r_rdata;
    logic [ADDR_W-1:0] mem_raddr;
    logic [ADDR_W-1:0] mem_waddr;
    logic [63:0] mem_wdata;
    logic        mem_we;

    t_state r_state, n_state;
    logic [GROUP_W-1:0] r_g, n_g;
    logic [WORD_W-1:0]  r_w, n_w;
    logic [5:0]  r_b, n_b;
    logic [1:0]  r_status, n_status;
    logic [17:0] r_id, n_id;
    logic [17:0] r_div, n_div;
    logic [13:0] r_rem, n_rem;
    logic [4:0]  r_step, n_step;
    logic [ADDR_W-1:0] r_clr, n_clr;
    logic [13:0] r_cnt [MAX_GROUPS];
    logic [13:0] n_cnt [MAX_GROUPS];
    logic [17:0] r_tot, n_tot;
    logic [17:0] r_cap;
    logic        r_ovalid, n_ovalid;
    t_rsp        r_out, n_out;

    logic [13:0] ipg;
    logic [4:0]  ng;
    logic [7:0]  nwords;
    logic [13:0] rem_bits;
    logic [63:0] mask, avail;
    logic [5:0]  first;
    logic [14:0] rem_sh;
    logic        div_ge;
    logic [13:0] used;
    logic [17:0] alloc_id;

    assign ipg    = (r_ipg_cfg > 14'(BITS_PER_GROUP)) ? 14'(BITS_PER_GROUP) : r_ipg_cfg;
    assign ng     = (r_ng_cfg > 5'(MAX_GROUPS)) ? 5'(MAX_GROUPS) : r_ng_cfg;
    assign nwords = 8'((15'(ipg) + 15'd63) >> 6);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ipg_cfg <= 14'd8192;
            r_ng_cfg  <= 5'd16;
            r_base    <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_ITEMS:  r_ipg_cfg <= i_cfg_data;
                CFG_GROUPS: r_ng_cfg  <= i_cfg_data[4:0];
                CFG_BASE:   r_base    <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        r_cap <= 18'(19'(ipg) * 19'(ng));
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        r_rdata <= mem[mem_raddr];
    end

    assign rem_bits = ipg - 14'({r_w, 6'b0});
    assign mask  = (rem_bits >= 14'd64) ? '1 : ((64'd1 << rem_bits[5:0]) - 64'd1);
    assign avail = ~r_rdata & mask;

    always_comb begin
        first = '0;
        for (int k = 63; k >= 0; k--) begin
            if (avail[k]) begin
                first = 6'(k);
            end
        end
    end

    assign rem_sh   = {r_rem, r_div[17]};
    assign div_ge   = rem_sh >= {1'b0, ipg};
    assign used     = r_cnt[r_g];
    assign alloc_id = 18'(18'(r_g) * 18'(ipg)) + 18'({r_w, r_b}) + 18'(r_base);
    assign mem_raddr = {r_g, r_w};

    assign i_req.ready = (r_state == S_IDLE);
    assign o_rsp.valid   = r_ovalid;
    assign o_rsp.payload = r_out;

    always_comb begin
        n_state  = r_state;
        n_g      = r_g;
        n_w      = r_w;
        n_b      = r_b;
        n_status = r_status;
        n_id     = r_id;
        n_div    = r_div;
        n_rem    = r_rem;
        n_step   = r_step;
        n_clr    = r_clr;
        n_cnt    = r_cnt;
        n_tot    = r_tot;
        n_ovalid = r_ovalid && !o_rsp.ready;
        n_out    = r_out;
        mem_we    = 1'b0;
        mem_waddr = {r_g, r_w};
        mem_wdata = r_rdata;

        unique case (r_state)
            S_CLEAR: begin
                mem_we    = 1'b1;
                mem_waddr = r_clr;
                mem_wdata = '0;
                n_clr     = r_clr + ADDR_W'(1);
                if (r_clr == ADDR_W'(DEPTH - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_req.valid) begin
                    n_id = i_req.payload.item_id;
                    n_g  = '0;
                    n_w  = '0;
                    if (i_req.payload.req_type == REQ_ALLOC) begin
                        if (ng == 5'd0 || nwords == 8'd0) begin
                            n_status = ST_FULL;
                            n_state  = S_FIN;
                        end else begin
                            n_state = S_A_RD;
                        end
                    end else if (i_req.payload.item_id == 18'd0 || ipg == 14'd0) begin
                        n_status = ST_RANGE;
                        n_state  = S_FIN;
                    end else begin
                        n_div   = i_req.payload.item_id - 18'(r_base);
                        n_rem   = '0;
                        n_step  = '0;
                        n_state = S_DIV;
                    end
                end
            end
            S_A_RD: begin
                n_state = S_A_CHK;
            end
            S_A_CHK: begin
                if (avail != '0) begin
                    mem_we    = 1'b1;
                    mem_wdata = r_rdata | (64'd1 << first);
                    n_b       = first;
                    n_cnt[r_g] = r_cnt[r_g] + 14'd1;
                    n_tot     = r_tot + 18'd1;
                    n_status  = ST_OK;
                    n_state   = S_FIN;
                end else if (8'(r_w) + 8'd1 == nwords) begin
                    if (5'(r_g) + 5'd1 == ng) begin
                        n_status = ST_FULL;
                        n_state  = S_FIN;
                    end else begin
                        n_g     = r_g + GROUP_W'(1);
                        n_w     = '0;
                        n_state = S_A_RD;
                    end
                end else begin
                    n_w     = r_w + WORD_W'(1);
                    n_state = S_A_RD;
                end
            end
            S_DIV: begin
                n_rem  = div_ge ? 14'(rem_sh - {1'b0, ipg}) : rem_sh[13:0];
                n_div  = {r_div[16:0], div_ge};
                n_step = r_step + 5'd1;
                if (r_step == 5'd17) begin
                    n_state = S_F_RD;
                end
            end
            S_F_RD: begin
                // Quotient and remainder are final here; the read is issued next cycle.
                if (r_div >= 18'(ng)) begin
                    n_status = ST_RANGE;
                    n_state  = S_FIN;
                end else begin
                    n_g     = r_div[GROUP_W-1:0];
                    n_w     = r_rem[12:6];
                    n_b     = r_rem[5:0];
                    n_status = ST_OK;
                    n_state = S_F_CHK;
                end
            end
            S_F_CHK: begin
                if (r_step != 5'd0) begin
                    n_step  = 5'd0;
                end else if (!r_rdata[r_b]) begin
                    n_status = ST_ALREADY;
                    n_state  = S_FIN;
                end else begin
                    mem_we    = 1'b1;
                    mem_wdata = r_rdata & ~(64'd1 << r_b);
                    if (r_cnt[r_g] != 14'd0) begin
                        n_cnt[r_g] = r_cnt[r_g] - 14'd1;
                    end
                    if (r_tot != 18'd0) begin
                        n_tot = r_tot - 18'd1;
                    end
                    n_status = ST_OK;
                    n_state  = S_FIN;
                end
            end
            S_FIN: begin
                if (!r_ovalid || o_rsp.ready) begin
                    n_ovalid = 1'b1;
                    n_out.status      = r_status;
                    n_out.total_free  = (r_tot >= r_cap) ? 18'd0 : r_cap - r_tot;
                    if (t_status'(r_status) == ST_OK) begin
                        n_out.result_id   = (r_step == 5'd0) ? r_id : alloc_id;
                        n_out.group_index = r_g;
                        n_out.group_free  = (used >= ipg) ? 14'd0 : ipg - used;
                    end else begin
                        n_out.result_id   = '0;
                        n_out.group_index = '0;
                        n_out.group_free  = '0;
                    end
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase

        // Alloc marks itself with a nonzero step so the result takes the computed id.
        if (r_state == S_IDLE && i_req.valid && i_req.payload.req_type == REQ_ALLOC) begin
            n_step = 5'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_CLEAR;
            r_clr    <= '0;
            r_tot    <= '0;
            r_ovalid <= 1'b0;
            for (int k = 0; k < MAX_GROUPS; k++) begin
                r_cnt[k] <= '0;
            end
        end else begin
            r_state  <= n_state;
            r_clr    <= n_clr;
            r_tot    <= n_tot;
            r_ovalid <= n_ovalid;
            r_cnt    <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_g      <= n_g;
        r_w      <= n_w;
        r_b      <= n_b;
        r_status <= n_status;
        r_id     <= n_id;
        r_div    <= n_div;
        r_rem    <= n_rem;
        r_step   <= n_step;
        r_out    <= n_out;
    end

    a_no_write_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> !mem_we)
        else $error("bitmap written while idle");

    a_leave_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_req.valid && i_req.ready) |=> (r_state != S_IDLE))
        else $error("accepted word did not start work");

    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp.valid && o_rsp.payload.status != ST_OK) |->
        (o_rsp.payload.result_id == 18'd0 && o_rsp.payload.group_index == 4'd0))
        else $error("error result carries an id");

    a_tot_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_tot <= 18'(MAX_GROUPS * BITS_PER_GROUP))
        else $error("total used count overflow");

endmodule

>>> bench/tb.sv
// Self-checking bench for grouped_bitmap_allocator: random and directed alloc/free words,
// checked against an in-bench first-fit bitmap predictor across several geometries.
// Depends on gba_pkg, gba_req_if, gba_rsp_if and the allocator RTL.
module tb;
    import gba_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic REQ_FREE = 1'b1;

    class alloc_scoreboard;
        bit          used_map [MAX_GROUPS][BITS_PER_GROUP];
        int unsigned group_used [MAX_GROUPS];
        int unsigned total_used;
        int unsigned ipg_reg;
        int unsigned groups_reg;
        int unsigned base_reg;
        t_rsp        pending [$];
        int          fails;

        function new();
            ipg_reg = 8192;
            groups_reg = 16;
            base_reg = 0;
            total_used = 0;
            fails = 0;
            foreach (group_used[g]) group_used[g] = 0;
            foreach (used_map[g, b]) used_map[g][b] = 0;
        endfunction

        function void write_reg(t_cfg_idx idx, logic [13:0] val);
            case (idx)
                CFG_ITEMS:  ipg_reg = val;
                CFG_GROUPS: groups_reg = val[4:0];
                CFG_BASE:   base_reg = val[0];
                default: ;
            endcase
        endfunction

        function int unsigned eff_ipg();
            return (ipg_reg > BITS_PER_GROUP) ? BITS_PER_GROUP : ipg_reg;
        endfunction

        function int unsigned eff_groups();
            return (groups_reg > MAX_GROUPS) ? MAX_GROUPS : groups_reg;
        endfunction

        function t_rsp error_word(t_status st, int unsigned tfree);
            t_rsp r;
            r = '0;
            r.status = st;
            r.total_free = tfree[17:0];
            return r;
        endfunction

        function void note_request(t_req req);
            int unsigned ipg, ng, cap, tfree, v, g, b, gf;
            bit          found;
            t_rsp        r;
            ipg = eff_ipg();
            ng = eff_groups();
            found = 0;
            r = '0;
            if (req.req_type != REQ_FREE) begin
                for (g = 0; g < ng && !found; g++) begin
                    for (b = 0; b < ipg; b++) begin
                        if (!used_map[g][b]) begin
                            used_map[g][b] = 1;
                            group_used[g]++;
                            total_used++;
                            found = 1;
                            v = g * ipg + b + base_reg;
                            r.result_id = v[17:0];
                            r.group_index = g[3:0];
                            gf = (group_used[g] >= ipg) ? 0 : ipg - group_used[g];
                            r.group_free = gf[13:0];
                            break;
                        end
                    end
                    if (found) break;
                end
            end
            cap = ipg * ng;
            tfree = (total_used >= cap) ? 0 : cap - total_used;
            if (req.req_type != REQ_FREE) begin
                if (found) begin
                    r.status = ST_OK;
                    r.total_free = tfree[17:0];
                end else begin
                    r = error_word(ST_FULL, tfree);
                end
            end else if (req.item_id == 0 || ipg == 0) begin
                r = error_word(ST_RANGE, tfree);
            end else begin
                v = req.item_id - base_reg;
                g = v / ipg;
                b = v % ipg;
                if (g >= ng) begin
                    r = error_word(ST_RANGE, tfree);
                end else if (!used_map[g][b]) begin
                    r = error_word(ST_ALREADY, tfree);
                end else begin
                    used_map[g][b] = 0;
                    if (group_used[g] > 0) group_used[g]--;
                    if (total_used > 0) total_used--;
                    tfree = (total_used >= cap) ? 0 : cap - total_used;
                    gf = (group_used[g] >= ipg) ? 0 : ipg - group_used[g];
                    r.status = ST_OK;
                    r.result_id = req.item_id;
                    r.group_index = g[3:0];
                    r.group_free = gf[13:0];
                    r.total_free = tfree[17:0];
                end
            end
            pending.push_back(r);
        endfunction

        function void check_result(t_rsp got);
            t_rsp want;
            if (pending.size() == 0) begin
                $error("result word with no expectation: %h", got);
                fails++;
                return;
            end
            want = pending.pop_front();
            if (got.status !== want.status) begin
                $error("status expected %0d actual %0d", want.status, got.status);
                fails++;
            end
            if (got.result_id !== want.result_id) begin
                $error("result_id expected %0d actual %0d", want.result_id, got.result_id);
                fails++;
            end
            if (got.group_index !== want.group_index) begin
                $error("group_index expected %0d actual %0d", want.group_index,
                       got.group_index);
                fails++;
            end
            if (got.group_free !== want.group_free) begin
                $error("group_free expected %0d actual %0d", want.group_free, got.group_free);
                fails++;
            end
            if (got.total_free !== want.total_free) begin
                $error("total_free expected %0d actual %0d", want.total_free, got.total_free);
                fails++;
            end
        endfunction
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic [1:0]  i_cfg_idx;
    logic [13:0] i_cfg_data;
    bit          calm;

    gba_req_if req_ch ();
    gba_rsp_if rsp_ch ();

    alloc_scoreboard sb;

    grouped_bitmap_allocator uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_req      (req_ch),
        .o_rsp      (rsp_ch)
    );

    always begin
        i_clk = 1'b0;
        #10;
        i_clk = 1'b1;
        #10;
    end

    function automatic int unsigned draw_gap();
        return calm ? 0 : $urandom_range(0, 4);
    endfunction

    task automatic send_word(logic kind, logic [17:0] id);
        int unsigned gap;
        t_req r;
        gap = draw_gap();
        if (gap > 0) begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        r.req_type = kind;
        r.item_id = id;
        req_ch.valid <= 1'b1;
        req_ch.payload <= r;
        @(posedge i_clk);
        while (!req_ch.ready) @(posedge i_clk);
        sb.note_request(r);
    endtask

    task automatic drain();
        req_ch.valid <= 1'b0;
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    task automatic set_geometry(int unsigned ipg, int unsigned ng, int unsigned base);
        drain();
        i_cfg_we <= 1'b1;
        i_cfg_idx <= CFG_ITEMS;
        i_cfg_data <= ipg[13:0];
        sb.write_reg(CFG_ITEMS, ipg[13:0]);
        @(posedge i_clk);
        i_cfg_idx <= CFG_GROUPS;
        i_cfg_data <= ng[13:0];
        sb.write_reg(CFG_GROUPS, ng[13:0]);
        @(posedge i_clk);
        i_cfg_idx <= CFG_BASE;
        i_cfg_data <= base[13:0];
        sb.write_reg(CFG_BASE, base[13:0]);
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic run_phase(int unsigned count, int unsigned alloc_pct, bit hold_mid);
        int unsigned span;
        logic [17:0] id;
        for (int n = 0; n < count; n++) begin
            if (hold_mid && n == count / 2) drain();
            span = sb.eff_ipg() * sb.eff_groups() + sb.base_reg + 1;
            if (span < 4) span = 4;
            if ($urandom_range(1, 100) <= alloc_pct) begin
                send_word(REQ_ALLOC, 18'($urandom));
            end else begin
                if ($urandom_range(0, 3) == 0) id = 18'($urandom);
                else id = 18'($urandom_range(0, span));
                send_word(REQ_FREE, id);
            end
        end
    endtask

    initial begin
        rsp_ch.ready = 1'b0;
        @(posedge i_clk);
        forever begin
            int unsigned gap;
            gap = draw_gap();
            if (gap > 0) begin
                rsp_ch.ready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            rsp_ch.ready <= 1'b1;
            @(posedge i_clk);
            while (!rsp_ch.valid) @(posedge i_clk);
            sb.check_result(rsp_ch.payload);
        end
    end

    initial begin
        #200_000_000;
        $display("status: fail");
        $finish;
    end

    initial begin
        sb = new();
        calm = 1'b0;
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_idx = CFG_NONE;
        i_cfg_data = '0;
        req_ch.valid = 1'b0;
        req_ch.payload = '0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed words at the reset geometry and at several edge geometries.
        send_word(REQ_ALLOC, 18'h3FFFF);
        send_word(REQ_ALLOC, 18'h0);
        send_word(REQ_FREE, 18'd0);
        send_word(REQ_FREE, 18'h3FFFF);
        send_word(REQ_FREE, 18'd131072);
        send_word(REQ_FREE, 18'd131071);
        send_word(REQ_FREE, 18'd1);
        send_word(REQ_FREE, 18'd1);
        send_word(REQ_ALLOC, 18'h2AAAA);
        send_word(REQ_FREE, 18'd0);
        set_geometry(8, 1, 1);
        send_word(REQ_FREE, 18'd0);
        send_word(REQ_FREE, 18'd1);
        send_word(REQ_ALLOC, 18'h15555);
        send_word(REQ_FREE, 18'd9);
        send_word(REQ_FREE, 18'd8);
        send_word(REQ_FREE, 18'd3);
        set_geometry(0, 2, 0);
        send_word(REQ_ALLOC, 18'h0);
        send_word(REQ_FREE, 18'd1);
        set_geometry(16, 0, 1);
        send_word(REQ_ALLOC, 18'h0);
        send_word(REQ_FREE, 18'd1);
        set_geometry(16383, 31, 1);
        send_word(REQ_ALLOC, 18'h0);
        send_word(REQ_FREE, 18'd131072);
        send_word(REQ_FREE, 18'd131073);

        set_geometry(8, 1, 0);
        run_phase(40, 75, 1'b0);
        calm = 1'b1;
        set_geometry(8, 2, 1);
        run_phase(50, 60, 1'b0);
        calm = 1'b0;
        set_geometry(20, 3, 1);
        run_phase(60, 55, 1'b1);
        set_geometry(64, 4, 0);
        run_phase(60, 60, 1'b0);
        calm = 1'b1;
        set_geometry(100, 16, 0);
        run_phase(60, 55, 1'b0);
        calm = 1'b0;
        set_geometry(0, 2, 0);
        run_phase(15, 50, 1'b0);
        set_geometry(16, 0, 1);
        run_phase(15, 50, 1'b0);
        set_geometry(16383, 31, 1);
        run_phase(40, 50, 1'b0);
        set_geometry(13, 5, 1);
        run_phase(80, 50, 1'b0);
        set_geometry(8192, 16, 0);
        run_phase(40, 50, 1'b0);
        set_geometry(8, 16, 1);
        run_phase(80, 55, 1'b0);

        drain();
        repeat (50) @(posedge i_clk);
        if (sb.fails == 0 && sb.pending.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end
endmodule

>>> sim.f
design/gba_pkg.sv
design/gba_req_if.sv
design/gba_rsp_if.sv
design/grouped_bitmap_allocator.sv
bench/tb.sv
